/* design/nearest_neighbor_downscaler_core_defines.svh */
// Assertion macros shared by the downscaler RTL
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define NND_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define NND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nnd_pkg.sv */
// Shared constants, codes and control types of the downscaler
`timescale 1ns / 1ps
`default_nettype none

package nnd_pkg;

  // Field widths
  localparam int SIDE_W       = 14;
  localparam int PIX_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_NUM_W    = 2 * SIDE_W;
  localparam int MAX_SIDE_DEF = 8192;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_MAX_SIDE   = 2'd2
  } cfg_idx_t;

  // Which quotient the shared divider is working on
  typedef enum logic [1:0] {
    DIV_SIDE = 2'd0,
    DIV_COL  = 2'd1,
    DIV_ROW  = 2'd2
  } div_op_t;

  // Setup sequencer states
  typedef enum logic [2:0] {
    ST_PREP,
    ST_SIDE_GO,
    ST_SIDE_WAIT,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_ROW_GO,
    ST_ROW_WAIT,
    ST_RUN
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    clear_frame;
    logic    prep;
    logic    div_start;
    div_op_t div_op;
    logic    latch_side;
    logic    latch_col;
    logic    latch_row;
    logic    run;
  } nnd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } nnd_sts_t;

endpackage

`default_nettype wire

/* design/nnd_div.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_downscaler_core_defines.svh"

module nnd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nnd_pkg::DIV_NUM_W-1:0] num,
  input  logic [nnd_pkg::SIDE_W-1:0]    den,
  output logic [nnd_pkg::DIV_NUM_W-1:0] quo,
  output logic [nnd_pkg::SIDE_W-1:0]    rem,
  output logic                         done
);
  import nnd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [SIDE_W-1:0]    rem_r, rem_nxt;
  logic [SIDE_W-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SIDE_W:0]      rem_sh;
  logic [SIDE_W:0]      diff;
  logic                 ge;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  // Load on start, iterate while busy, pulse done after the last bit
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? diff[SIDE_W-1:0] : rem_sh[SIDE_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

  `NND_ASSERT_NOW(a_div_rem_below_den, clk, rst_n, done_r, rem_r < den_r, "divider remainder not below divisor")

endmodule

`default_nettype wire

/* design/nnd_ctrl.sv */
// Setup sequencer: output size and step quotients, then pixel run
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_downscaler_core_defines.svh"

module nnd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  nnd_pkg::nnd_sts_t sts,
  output nnd_pkg::nnd_cmd_t cmd
);
  import nnd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (restart) begin
      state_nxt = ST_PREP;
    end else begin
      unique case (state_r)
        ST_PREP:      state_nxt = ST_SIDE_GO;
        ST_SIDE_GO:   state_nxt = ST_SIDE_WAIT;
        ST_SIDE_WAIT: if (sts.div_done) state_nxt = ST_COL_GO;
        ST_COL_GO:    state_nxt = ST_COL_WAIT;
        ST_COL_WAIT:  if (sts.div_done) state_nxt = ST_ROW_GO;
        ST_ROW_GO:    state_nxt = ST_ROW_WAIT;
        ST_ROW_WAIT:  if (sts.div_done) state_nxt = ST_RUN;
        ST_RUN:       state_nxt = ST_RUN;
        default:      state_nxt = ST_PREP;
      endcase
    end
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.div_op = DIV_SIDE;
    unique case (state_r)
      ST_PREP: begin
        cmd.clear_frame = 1'b1;
        cmd.prep        = 1'b1;
      end
      ST_SIDE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_SIDE;
      end
      ST_SIDE_WAIT: begin
        cmd.div_op     = DIV_SIDE;
        cmd.latch_side = sts.div_done;
      end
      ST_COL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_COL;
      end
      ST_COL_WAIT: begin
        cmd.div_op    = DIV_COL;
        cmd.latch_col = sts.div_done;
      end
      ST_ROW_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_ROW;
      end
      ST_ROW_WAIT: begin
        cmd.div_op    = DIV_ROW;
        cmd.latch_row = sts.div_done;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
      end
      default: begin
        cmd.run = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PREP;
    end else begin
      state_r <= state_nxt;
    end
  end

  `NND_ASSERT_NEXT(a_restart_to_prep, clk, rst_n, restart, state_r == ST_PREP, "config write did not restart setup")

endmodule

`default_nettype wire

/* design/nnd_dp.sv */
// Datapath: size setup, pick tracking and output word register
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_downscaler_core_defines.svh"

module nnd_dp #(
  parameter int MAX_SIDE = nnd_pkg::MAX_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [nnd_pkg::SIDE_W-1:0] src_width,
  input  logic [nnd_pkg::SIDE_W-1:0] src_height,
  input  logic [nnd_pkg::SIDE_W-1:0] max_side,
  input  nnd_pkg::nnd_cmd_t         cmd,
  output nnd_pkg::nnd_sts_t         sts,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [nnd_pkg::PIX_W-1:0]  in_red,
  input  logic [nnd_pkg::PIX_W-1:0]  in_green,
  input  logic [nnd_pkg::PIX_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [nnd_pkg::PIX_W-1:0]  out_red,
  output logic [nnd_pkg::PIX_W-1:0]  out_green,
  output logic [nnd_pkg::PIX_W-1:0]  out_blue,
  output logic [nnd_pkg::SIDE_W-1:0] out_width,
  output logic [nnd_pkg::SIDE_W-1:0] out_height,
  output logic                      out_frame_last
);
  import nnd_pkg::*;

  typedef struct packed {
    logic [SIDE_W-1:0] pos;
    logic [SIDE_W-1:0] rem;
  } pick_t;

  // Advance floor(k*src/dst) to k+1 from quotient and remainder of src/dst
  function automatic pick_t pick_step(input logic [SIDE_W-1:0] pos,
                                      input logic [SIDE_W-1:0] rem,
                                      input logic [SIDE_W-1:0] q_inc,
                                      input logic [SIDE_W-1:0] r_inc,
                                      input logic [SIDE_W-1:0] dst);
    logic [SIDE_W:0] sum;
    pick_t           res;
    sum = {1'b0, rem} + {1'b0, r_inc};
    if (sum >= {1'b0, dst}) begin
      res.rem = SIDE_W'(sum - {1'b0, dst});
      res.pos = pos + q_inc + SIDE_W'(1);
    end else begin
      res.rem = sum[SIDE_W-1:0];
      res.pos = pos + q_inc;
    end
    return res;
  endfunction

  logic [SIDE_W-1:0] w_eff, h_eff, m_eff;
  logic              w_ge_h, scale_en;
  logic [SIDE_W-1:0] short_side, long_side;

  logic [DIV_NUM_W-1:0] prod_r;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [SIDE_W-1:0]    div_den, div_rem;
  logic                 div_done;
  logic [SIDE_W-1:0]    q_side;

  logic [SIDE_W-1:0] dw_r, dw_nxt, dh_r, dh_nxt;
  logic [SIDE_W-1:0] qw_r, rw_r, qh_r, rh_r;

  logic [SIDE_W-1:0] sc_r, sc_nxt, sr_r, sr_nxt;
  logic [SIDE_W-1:0] oc_r, oc_nxt, orow_r, orow_nxt;
  logic [SIDE_W-1:0] npc_r, npc_nxt, npr_r, npr_nxt;
  logic [SIDE_W-1:0] crem_r, crem_nxt, rrem_r, rrem_nxt;

  logic  accept, row_picked, keep, row_end, frame_end, is_last;
  pick_t col_step, row_step;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  red_r, green_r, blue_r;
  logic              last_r;

  // Clamp the configured sides
  always_comb begin
    if (src_width == '0)
      w_eff = SIDE_W'(1);
    else if (int'(src_width) > MAX_SIDE)
      w_eff = SIDE_W'(MAX_SIDE);
    else
      w_eff = src_width;
    if (src_height == '0)
      h_eff = SIDE_W'(1);
    else if (int'(src_height) > MAX_SIDE)
      h_eff = SIDE_W'(MAX_SIDE);
    else
      h_eff = src_height;
    if (int'(max_side) > MAX_SIDE)
      m_eff = SIDE_W'(MAX_SIDE);
    else
      m_eff = max_side;
    w_ge_h     = w_eff >= h_eff;
    scale_en   = (m_eff != '0) && ((w_eff > m_eff) || (h_eff > m_eff));
    short_side = w_ge_h ? h_eff : w_eff;
    long_side  = w_ge_h ? w_eff : h_eff;
  end

  // Register short side times max side for the size division
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod_r <= DIV_NUM_W'(short_side) * DIV_NUM_W'(m_eff);
    end
  end

  // Pick the divider operands
  always_comb begin
    case (cmd.div_op)
      DIV_SIDE: begin
        div_num = prod_r;
        div_den = long_side;
      end
      DIV_COL: begin
        div_num = DIV_NUM_W'(w_eff);
        div_den = dw_r;
      end
      DIV_ROW: begin
        div_num = DIV_NUM_W'(h_eff);
        div_den = dh_r;
      end
      default: begin
        div_num = prod_r;
        div_den = long_side;
      end
    endcase
  end

  nnd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  assign sts.div_done = div_done;

  // Output size: unscaled sides pass through; when scaling, long side takes max side, short side the scaled quotient
  always_comb begin
    q_side = (div_quo[SIDE_W-1:0] == '0) ? SIDE_W'(1) : div_quo[SIDE_W-1:0];
    dw_nxt = dw_r;
    dh_nxt = dh_r;
    if (cmd.latch_side) begin
      if (!scale_en) begin
        dw_nxt = w_eff;
        dh_nxt = h_eff;
      end else if (w_ge_h) begin
        dw_nxt = m_eff;
        dh_nxt = q_side;
      end else begin
        dw_nxt = q_side;
        dh_nxt = m_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r <= SIDE_W'(1);
      dh_r <= SIDE_W'(1);
    end else begin
      dw_r <= dw_nxt;
      dh_r <= dh_nxt;
    end
  end

  // Hold the per-step quotient and remainder of each axis
  always_ff @(posedge clk) begin
    if (cmd.latch_col) begin
      qw_r <= div_quo[SIDE_W-1:0];
      rw_r <= div_rem;
    end
    if (cmd.latch_row) begin
      qh_r <= div_quo[SIDE_W-1:0];
      rh_r <= div_rem;
    end
  end

  // Pick decision for the current source pixel
  always_comb begin
    in_stall   = !cmd.run || (out_valid_r && out_stall);
    accept     = in_valid && !in_stall;
    row_picked = (orow_r < dh_r) && (sr_r == npr_r);
    keep       = row_picked && (oc_r < dw_r) && (sc_r == npc_r);
    row_end    = ({1'b0, sc_r} + (SIDE_W+1)'(1)) >= {1'b0, w_eff};
    frame_end  = row_end && (({1'b0, sr_r} + (SIDE_W+1)'(1)) >= {1'b0, h_eff});
    is_last    = (({1'b0, orow_r} + (SIDE_W+1)'(1)) == {1'b0, dh_r}) &&
                 (({1'b0, oc_r} + (SIDE_W+1)'(1)) == {1'b0, dw_r});
    col_step   = pick_step(npc_r, crem_r, qw_r, rw_r, dw_r);
    row_step   = pick_step(npr_r, rrem_r, qh_r, rh_r, dh_r);
  end

  // Advance source and output positions
  always_comb begin
    sc_nxt   = sc_r;
    sr_nxt   = sr_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    npc_nxt  = npc_r;
    npr_nxt  = npr_r;
    crem_nxt = crem_r;
    rrem_nxt = rrem_r;
    if (cmd.clear_frame) begin
      sc_nxt   = '0;
      sr_nxt   = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
      npc_nxt  = '0;
      npr_nxt  = '0;
      crem_nxt = '0;
      rrem_nxt = '0;
    end else if (accept) begin
      if (keep) begin
        oc_nxt   = oc_r + SIDE_W'(1);
        npc_nxt  = col_step.pos;
        crem_nxt = col_step.rem;
      end
      if (row_end) begin
        sc_nxt = '0;
        sr_nxt = sr_r + SIDE_W'(1);
        if (row_picked) begin
          orow_nxt = orow_r + SIDE_W'(1);
          oc_nxt   = '0;
          npc_nxt  = '0;
          crem_nxt = '0;
          npr_nxt  = row_step.pos;
          rrem_nxt = row_step.rem;
        end
        if (frame_end) begin
          sr_nxt   = '0;
          orow_nxt = '0;
          oc_nxt   = '0;
          npc_nxt  = '0;
          crem_nxt = '0;
          npr_nxt  = '0;
          rrem_nxt = '0;
        end
      end else begin
        sc_nxt = sc_r + SIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      sr_r   <= '0;
      oc_r   <= '0;
      orow_r <= '0;
      npc_r  <= '0;
      npr_r  <= '0;
      crem_r <= '0;
      rrem_r <= '0;
    end else begin
      sc_r   <= sc_nxt;
      sr_r   <= sr_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
      npc_r  <= npc_nxt;
      npr_r  <= npr_nxt;
      crem_r <= crem_nxt;
      rrem_r <= rrem_nxt;
    end
  end

  // Output word register: load on a kept pixel, drop once taken
  always_comb begin
    if (accept && keep)
      out_valid_nxt = 1'b1;
    else
      out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      last_r  <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_width      = dw_r;
  assign out_height     = dh_r;
  assign out_frame_last = last_r;

  `NND_ASSERT_NOW(a_pick_rem_bound, clk, rst_n, cmd.run, (crem_r < dw_r) && (rrem_r < dh_r), "pick remainder out of range")
  `NND_ASSERT_NOW(a_pick_pos_bound, clk, rst_n, cmd.run, (npc_r <= w_eff) && (npr_r <= h_eff), "pick position beyond source frame")

endmodule

`default_nettype wire

/* design/nearest_neighbor_downscaler_core.sv */
// Top level of the nearest-neighbor downscaler
// Usage:
//   Source pixels enter on in_valid/in_stall in raster order, one word per
//   pixel. Kept pixels leave on out_valid/out_stall in output raster order,
//   each with the output frame size and a frame-last flag on the final one.
//   cfg_we/cfg_index/cfg_wdata write source width, source height and max
//   side; a write to a listed register restarts the frame and recomputes the
//   output size. Write only while no pixel is in flight.
// Setup and rate:
//   After reset or a config write the block runs a setup (one product step,
//   then three divisions of load, 28 quotient bits and done on one shared
//   restoring divider) with in_stall high. Then it takes one pixel per clock
//   while the output register is not held by out_stall; a kept pixel shows on
//   the output in the cycle after it is accepted, from the output word register.
// Stall behavior:
//   While a result word sits in the output register and out_stall is high,
//   in_stall is raised, so nothing is lost or repeated.
// Reset:
//   rst_n low clears the size registers to 1x1 with no limit, empties the
//   output register and starts the setup.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_downscaler_core #(
  parameter int MAX_SIDE = nnd_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnd_pkg::SIDE_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nnd_pkg::PIX_W-1:0]     in_red,
  input  logic [nnd_pkg::PIX_W-1:0]     in_green,
  input  logic [nnd_pkg::PIX_W-1:0]     in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nnd_pkg::PIX_W-1:0]     out_red,
  output logic [nnd_pkg::PIX_W-1:0]     out_green,
  output logic [nnd_pkg::PIX_W-1:0]     out_blue,
  output logic [nnd_pkg::SIDE_W-1:0]    out_width,
  output logic [nnd_pkg::SIDE_W-1:0]    out_height,
  output logic                         out_frame_last
);
  import nnd_pkg::*;

  logic [SIDE_W-1:0] src_width_r, src_width_nxt;
  logic [SIDE_W-1:0] src_height_r, src_height_nxt;
  logic [SIDE_W-1:0] max_side_r, max_side_nxt;
  logic              restart;
  nnd_cmd_t          cmd;
  nnd_sts_t          sts;

  // Decode config writes; only listed registers restart the frame
  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    max_side_nxt   = max_side_r;
    restart        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH: begin
          src_width_nxt = cfg_wdata;
          restart       = 1'b1;
        end
        CFG_SRC_HEIGHT: begin
          src_height_nxt = cfg_wdata;
          restart        = 1'b1;
        end
        CFG_MAX_SIDE: begin
          max_side_nxt = cfg_wdata;
          restart      = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIDE_W'(1);
      src_height_r <= SIDE_W'(1);
      max_side_r   <= '0;
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      max_side_r   <= max_side_nxt;
    end
  end

  nnd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .sts     (sts),
    .cmd     (cmd)
  );

  nnd_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_width      (src_width_r),
    .src_height     (src_height_r),
    .max_side       (max_side_r),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

/* tb/nearest_neighbor_downscaler_core_tb.sv */
// Self-checking testbench for the nearest-neighbor downscaler core
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_core_tb;
  import nnd_pkg::*;

  localparam int unsigned LARGEST_SIDE = MAX_SIDE_DEF;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 4;
  // Index past the register list; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_FULL} stall_mode_t;
  typedef enum {SHAPE_WIDE, SHAPE_TALL, SHAPE_SMALL} frame_shape_t;

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              last;
  } kept_pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIDE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_red;
  logic [PIX_W-1:0]     in_green;
  logic [PIX_W-1:0]     in_blue;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic [SIDE_W-1:0]    out_width;
  logic [SIDE_W-1:0]    out_height;
  logic                 out_frame_last;

  // Expected kept pixels, oldest first
  kept_pixel_t expected_pixels[$];
  int unsigned mismatches;
  int unsigned burst_left;
  bit          hold_req;
  bit          hold_active;

  // Shadow registers and scan position of the downscaler
  logic [SIDE_W-1:0] shadow_src_w;
  logic [SIDE_W-1:0] shadow_src_h;
  logic [SIDE_W-1:0] shadow_max;
  int unsigned src_col, src_row;
  int unsigned dst_col, dst_row;
  int unsigned pick_col, pick_row;
  int unsigned dst_w, dst_h;

  nearest_neighbor_downscaler_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_frame_last (out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sides are used clamped to 1..LARGEST_SIDE
  function automatic int unsigned clamp_side(logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (32'(v) > LARGEST_SIDE) return LARGEST_SIDE;
    return 32'(v);
  endfunction

  // Recompute the output size and rewind to the top of the frame
  function automatic void restart_scan();
    int unsigned w, h, m;
    w = clamp_side(shadow_src_w);
    h = clamp_side(shadow_src_h);
    m = (32'(shadow_max) > LARGEST_SIDE) ? LARGEST_SIDE : 32'(shadow_max);
    dst_w = w;
    dst_h = h;
    if (m > 0 && (w > m || h > m)) begin
      if (w >= h) begin
        dst_w = m;
        dst_h = (h * m) / w;
      end else begin
        dst_h = m;
        dst_w = (w * m) / h;
      end
      if (dst_w == 0) dst_w = 1;
      if (dst_h == 0) dst_h = 1;
    end
    src_col  = 0;
    src_row  = 0;
    dst_col  = 0;
    dst_row  = 0;
    pick_col = 0;
    pick_row = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] index, logic [SIDE_W-1:0] value);
    case (index)
      CFG_SRC_WIDTH:  shadow_src_w = value;
      CFG_SRC_HEIGHT: shadow_src_h = value;
      CFG_MAX_SIDE:   shadow_max   = value;
      default:        return;
    endcase
    restart_scan();
  endfunction

  // Step the scan by one source pixel; queue it if it lands on an output pixel
  function automatic void downscale_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                          logic [PIX_W-1:0] b);
    int unsigned w, h;
    bit          row_hit;
    kept_pixel_t px;
    w = clamp_side(shadow_src_w);
    h = clamp_side(shadow_src_h);
    row_hit = (dst_row < dst_h) && (src_row == pick_row);
    if (row_hit && dst_col < dst_w && src_col == pick_col) begin
      px.red    = r;
      px.green  = g;
      px.blue   = b;
      px.width  = dst_w[SIDE_W-1:0];
      px.height = dst_h[SIDE_W-1:0];
      px.last   = (dst_row + 1 == dst_h) && (dst_col + 1 == dst_w);
      expected_pixels.push_back(px);
      dst_col++;
      if (dst_col < dst_w) pick_col = (dst_col * w) / dst_w;
    end
    if (src_col + 1 >= w) begin
      src_col = 0;
      if (row_hit) begin
        dst_row++;
        dst_col  = 0;
        pick_col = 0;
        if (dst_row < dst_h) pick_row = (dst_row * h) / dst_h;
      end
      src_row++;
      if (src_row >= h) begin
        src_row  = 0;
        dst_row  = 0;
        dst_col  = 0;
        pick_col = 0;
        pick_row = 0;
      end
    end else begin
      src_col++;
    end
  endfunction

  // Write one register, then drop cfg_we again before returning
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [SIDE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    apply_register(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h, logic [SIDE_W-1:0] m);
    write_register(CFG_SRC_WIDTH, w);
    write_register(CFG_SRC_HEIGHT, h);
    write_register(CFG_MAX_SIDE, m);
  endtask

  // Offer one source word, with a random gap between bursts
  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    downscale_pixel(r, g, b);
  endtask

  task automatic send_random_pixels(int unsigned count);
    repeat (count) send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                              PIX_W'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // 1x1 frame out of reset: every word is kept and marked last
  task automatic test_reset_state();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hA5, 8'h5A, 8'hC3);
    settle();
  endtask

  // Zero and oversized sides and limit, and a limit that rounds a side to zero
  task automatic test_clamped_sizes();
    set_frame(14'd0, 14'h3FFF, 14'h3FFF);
    send_random_pixels(2);
    settle();
    set_frame(14'd8192, 14'd2, 14'd1);
    send_random_pixels(3);
    settle();
    set_frame(14'd1, 14'd8193, 14'd5);
    send_random_pixels(3);
    settle();
  endtask

  // Square frame shrunk with skipped rows and columns, then wrap into the next frame
  task automatic test_frame_wrap();
    set_frame(14'd3, 14'd3, 14'd2);
    send_random_pixels(11);
    settle();
  endtask

  // Write past the register list mid-frame; the scan must carry on
  task automatic test_spare_index();
    write_register(CFG_SPARE, 14'h2AAA);
    send_random_pixels(2);
    settle();
  endtask

  // Hold the output off for a long stretch while source words keep coming
  task automatic test_output_backpressure();
    set_frame(14'd8, 14'd8, 14'd0);
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    send_random_pixels(64);
    settle();
  endtask

  // Random frame sizes and limits; mostly whole frames, some cut short
  task automatic test_random_frames();
    int unsigned  w, h, m, longest, count, sent;
    frame_shape_t shape;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_WIDE;
        1:       shape = SHAPE_TALL;
        default: shape = SHAPE_SMALL;
      endcase
      case (shape)
        SHAPE_WIDE: begin
          w = $urandom_range(200, LARGEST_SIDE);
          h = $urandom_range(1, 3);
          count = $urandom_range(10, 60);
        end
        SHAPE_TALL: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(200, LARGEST_SIDE);
          count = $urandom_range(10, 60);
        end
        default: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 16);
          count = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
        end
      endcase
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      longest = (w > h) ? w : h;
      case ($urandom_range(0, 3))
        0:       m = 0;
        1:       m = $urandom_range(1, longest);
        2:       m = $urandom_range(0, 16383);
        default: m = $urandom_range(1, 32);
      endcase
      set_frame(SIDE_W'(w), SIDE_W'(h), SIDE_W'(m));
      if ($urandom_range(0, 5) == 0)
        write_register(CFG_SPARE, SIDE_W'($urandom_range(0, 16383)));
      send_random_pixels(count);
      sent += count;
      settle();
    end
  endtask

  // Receiver stall pattern, plus the long hold on request
  initial begin : out_stall_pattern
    stall_mode_t mode;
    int unsigned span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(1, 48);
        repeat (span) begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
            default:     out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin : output_check
    kept_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("output word with nothing expected");
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", 32'(want.red), 32'(out_red));
        check_field("out_green", 32'(want.green), 32'(out_green));
        check_field("out_blue", 32'(want.blue), 32'(out_blue));
        check_field("out_width", 32'(want.width), 32'(out_width));
        check_field("out_height", 32'(want.height), 32'(out_height));
        check_field("out_frame_last", 32'(want.last), 32'(out_frame_last));
      end
    end
  end

  // End the run after too many cycles in which nothing moves
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("nearest_neighbor_downscaler_core_tb: errors");
    $finish;
  end

  initial begin
    mismatches  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    shadow_src_w = SIDE_W'(1);
    shadow_src_h = SIDE_W'(1);
    shadow_max   = '0;
    restart_scan();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SRC_WIDTH;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_red    <= '0;
    in_green  <= '0;
    in_blue   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_clamped_sizes();
    test_frame_wrap();
    test_spare_index();
    test_output_backpressure();
    test_random_frames();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("nearest_neighbor_downscaler_core_tb: clean");
    else
      $display("nearest_neighbor_downscaler_core_tb: errors");
    $finish;
  end

endmodule
